// ===== hw/rtl/bounded_deque_with_search_delete_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque core
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DELETE_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DELETE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded deque package
// Sizes, operation and status codes, and cell control types.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;
  localparam logic [2:0] OP_SEARCH     = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    CA_HOLD,
    CA_SHIFT_RIGHT,
    CA_SHIFT_LEFT,
    CA_APPEND,
    CA_DELETE
  } cell_act_e;

  typedef struct packed {
    cell_act_e                 act;
    logic signed [DATA_W-1:0]  key;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic tail;
  } cell_slot_t;

endpackage

// ===== hw/rtl/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded deque cell
// Holds one entry, compares it with the key and shifts with its neighbors.
// ----------------------------------------------------------------------------
module bdq_cell
  import bdq_pkg::*;
(
  input  logic                      clk_i,
  input  cell_ctrl_t                ctrl_i,
  input  cell_slot_t                slot_i,
  input  logic signed [DATA_W-1:0]  left_data_i,
  input  logic signed [DATA_W-1:0]  right_data_i,
  input  logic                      seen_i,
  output logic signed [DATA_W-1:0]  data_o,
  output logic                      first_o,
  output logic                      seen_o
);

  logic signed [DATA_W-1:0] data_d, data_q;
  logic                     hit;

  assign hit     = slot_i.valid && (data_q == ctrl_i.key);
  assign seen_o  = seen_i | hit;
  assign first_o = hit & ~seen_i;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.act)
      CA_SHIFT_RIGHT: data_d = left_data_i;
      CA_SHIFT_LEFT:  data_d = right_data_i;
      CA_APPEND: begin
        if (slot_i.tail) data_d = ctrl_i.key;
      end
      CA_DELETE: begin
        if (seen_o) data_d = right_data_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== hw/rtl/bounded_deque_with_search_delete_core.sv =====
// A result strobes on done_o once an accepted start has passed through busy_q and then done_q.
// A new operation is not accepted while busy is high; busy is high for the cycle in
// which the cell row compares all entries in parallel and shifts.
// Reset clears the entry count and the busy and done flags; entry data is not reset.
// The receiver cannot stall: done_o is high for one cycle only; result fields hold until the next result.
// ----------------------------------------------------------------------------
// Bounded deque core
// Deque with search and delete, built as a row of shifting compare cells.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_delete_core_defines.svh"

module bounded_deque_with_search_delete_core
  import bdq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          operation_i,
  input  logic signed [31:0]  value_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic signed [31:0]  popped_value_o,
  output logic                found_o,
  output logic [3:0]          position_o,
  output logic [4:0]          entry_count_o
);

  logic                     busy_q;
  logic [2:0]               op_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         count_d, count_q;

  logic                     done_q;
  logic [1:0]               status_d, status_q;
  logic signed [DATA_W-1:0] popped_d, popped_q;
  logic                     found_d, found_q;
  logic [IDX_W-1:0]         pos_d, pos_q;

  logic                     accept;
  cell_act_e                act;
  cell_ctrl_t               ctrl;
  cell_slot_t               slot [DEPTH];
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic                     cell_first [DEPTH];
  logic                     seen [DEPTH+1];
  logic signed [DATA_W-1:0] back_data;
  logic [IDX_W-1:0]         match_idx;
  logic                     full, empty, any_match;

  assign accept    = start && !busy_q;
  assign busy      = busy_q;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign any_match = seen[DEPTH];
  assign seen[0]   = 1'b0;

  assign ctrl.act = busy_q ? act : CA_HOLD;
  assign ctrl.key = key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign slot[i].valid = (CNT_W'(i) < count_q);
    assign slot[i].tail  = (CNT_W'(i) == count_q);

    bdq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .slot_i       (slot[i]),
      .left_data_i  ((i == 0) ? key_q : cell_data[(i == 0) ? 0 : i-1]),
      .right_data_i (cell_data[(i == DEPTH-1) ? i : i+1]),
      .seen_i       (seen[i]),
      .data_o       (cell_data[i]),
      .first_o      (cell_first[i]),
      .seen_o       (seen[i+1])
    );
  end

  always_comb begin
    back_data = '0;
    match_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i + 1) == count_q) back_data = back_data | cell_data[i];
      if (cell_first[i])            match_idx = match_idx | IDX_W'(i);
    end
  end

  always_comb begin
    act      = CA_HOLD;
    count_d  = count_q;
    status_d = ST_OK;
    popped_d = '0;
    found_d  = 1'b0;
    pos_d    = '0;
    unique case (op_q) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          act     = (op_q == OP_PUSH_FRONT) ? CA_SHIFT_RIGHT : CA_APPEND;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          act      = (op_q == OP_POP_FRONT) ? CA_SHIFT_LEFT : CA_HOLD;
          popped_d = (op_q == OP_POP_FRONT) ? cell_data[0] : back_data;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_DELETE, OP_SEARCH: begin
        act = (op_q == OP_DELETE) ? CA_DELETE : CA_HOLD;
        if (any_match) begin
          found_d = 1'b1;
          pos_d   = match_idx;
          if (op_q == OP_DELETE) count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: begin
        act = CA_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= value_i;
    end
    if (busy_q) begin
      status_q <= status_d;
      popped_q <= popped_d;
      found_q  <= found_d;
      pos_q    <= pos_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign found_o        = found_q;
  assign position_o     = 4'(pos_q);
  assign entry_count_o  = 5'(count_q);

  `BDQ_ASSERT(a_done_after_busy, clk_i, rst_ni, busy |=> done_o && !busy, "no strobe after busy")
  `BDQ_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(DEPTH), "count above depth")
  `BDQ_ASSERT(a_full_ok, clk_i, rst_ni, done_o && status_o == ST_FULL |-> full, "spurious full")
  `BDQ_ASSERT(a_found_ok, clk_i, rst_ni, done_o && found_o |-> status_o == ST_OK, "bad found")

endmodule

// ===== sim/bounded_deque_with_search_delete_core_tb.sv =====
// ----------------------------------------------------------------------------
// Bounded deque core testbench
// Sends push, pop, delete, search and unused ops, some with random gaps
// between them. A shadow deque predicts every result, and each result
// strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_delete_core_tb;
  import bdq_pkg::*;

  localparam logic [2:0] OP_UNUSED_6  = 3'd6;
  localparam logic [2:0] OP_UNUSED_7  = 3'd7;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 8;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_bias_e;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic               found;
    logic [3:0]         position;
    logic [4:0]         entry_count;
  } deque_result_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic [2:0]         operation_i = '0;
  logic signed [31:0] value_i     = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] popped_value_o;
  logic               found_o;
  logic [3:0]         position_o;
  logic [4:0]         entry_count_o;

  logic signed [31:0] shadow_entries[$];
  deque_result_t      expected_results[$];
  bit                 idle_enable = 1'b1;
  int                 errors;
  int                 cycle_count;
  int                 ops_sent;
  int                 results_checked;
  int                 full_seen;
  int                 empty_seen;
  int                 hits_seen;
  int                 misses_seen;

  bounded_deque_with_search_delete_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .found_o        (found_o),
    .position_o     (position_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic deque_result_t apply_deque_op(input logic [2:0] op,
                                                   input logic signed [31:0] val);
    deque_result_t r;
    int            idx;
    r   = '0;
    idx = -1;
    r.status = ST_OK;
    case (op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_entries.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_entries.push_front(val);
        end else begin
          shadow_entries.push_back(val);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_entries.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.popped_value = shadow_entries.pop_front();
        end else begin
          r.popped_value = shadow_entries.pop_back();
        end
      end
      OP_DELETE, OP_SEARCH: begin
        foreach (shadow_entries[i]) begin
          if (idx < 0 && shadow_entries[i] == val) idx = i;
        end
        if (idx < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found    = 1'b1;
          r.position = idx[3:0];
          if (op == OP_DELETE) shadow_entries.delete(idx);
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 5'(shadow_entries.size());
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] exp_v,
                                      input logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    deque_result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no pending operation: status %0d, entry_count %0d",
               status_o, entry_count_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", exp_r.status, status_o);
        check_field("popped_value", exp_r.popped_value, popped_value_o);
        check_field("found", exp_r.found, found_o);
        check_field("position", exp_r.position, position_o);
        check_field("entry_count", exp_r.entry_count, entry_count_o);
        results_checked++;
      end
    end
  end

  task automatic send_item(input logic [2:0] op, input logic signed [31:0] val);
    deque_result_t r;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (busy);
    r = apply_deque_op(op, val);
    expected_results.push_back(r);
    ops_sent++;
    case (r.status)
      ST_FULL:     full_seen++;
      ST_EMPTY:    empty_seen++;
      ST_NOTFOUND: misses_seen++;
      default:     if (r.found) hits_seen++;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      4, 5, 6: return 32'($urandom_range(0, 15)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    if (shadow_entries.size() > 0 && $urandom_range(0, 99) < 70) begin
      return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
    end
    return pick_value();
  endfunction

  function automatic logic [2:0] pick_op(input mix_bias_e bias);
    int r;
    int push_w;
    int pop_w;
    r      = $urandom_range(0, 99);
    push_w = (bias == MIX_FILL) ? 60 : (bias == MIX_DRAIN) ? 20 : 35;
    pop_w  = (bias == MIX_DRAIN) ? 60 : (bias == MIX_FILL) ? 20 : 35;
    if (r < 2) return $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
    if (r < 2 + push_w) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    if (r < 2 + push_w + pop_w) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    return $urandom_range(0, 1) ? OP_SEARCH : OP_DELETE;
  endfunction

  task automatic send_random(input logic [2:0] op);
    case (op) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: send_item(op, pick_value());
      OP_DELETE, OP_SEARCH:        send_item(op, pick_key());
      default:                     send_item(op, $urandom);
    endcase
  endtask

  task automatic fill_to_full();
    while (shadow_entries.size() < DEPTH) begin
      send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
    end
  endtask

  task automatic test_empty_sequence();
    send_item(OP_POP_FRONT, 32'sd7);
    send_item(OP_POP_BACK, -32'sd7);
    send_item(OP_DELETE, 32'sd5);
    send_item(OP_SEARCH, 32'sd5);
    send_item(OP_UNUSED_6, 32'sh7fff_ffff);
    send_item(OP_UNUSED_7, 32'sh8000_0000);
  endtask

  task automatic test_directed_extremes();
    send_item(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_item(OP_PUSH_FRONT, 32'sh8000_0000);
    send_item(OP_PUSH_BACK, '0);
    send_item(OP_PUSH_FRONT, -32'sd1);
    send_item(OP_SEARCH, -32'sd1);
    send_item(OP_SEARCH, '0);
    send_item(OP_PUSH_BACK, 32'sh8000_0000);
    send_item(OP_DELETE, 32'sh8000_0000);
    send_item(OP_SEARCH, 32'sh8000_0000);
    send_item(OP_DELETE, 32'sd12345);
    send_item(OP_UNUSED_6, -32'sd1);
    send_item(OP_UNUSED_7, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, -32'sd1);
  endtask

  task automatic test_full_boundary();
    repeat (3) begin
      fill_to_full();
      send_item(OP_PUSH_FRONT, pick_value());
      send_item(OP_PUSH_BACK, pick_value());
      send_item(OP_SEARCH, shadow_entries[DEPTH-1]);
      send_item(OP_SEARCH, shadow_entries[0]);
      send_item($urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6, $urandom);
      while (shadow_entries.size() > 0) begin
        send_item($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
      end
      send_item(OP_POP_FRONT, $urandom);
      send_item(OP_POP_BACK, $urandom);
    end
  endtask

  task automatic test_random_ops(input int n_items);
    mix_bias_e bias;
    int        run_left;
    bias     = MIX_EVEN;
    run_left = 0;
    repeat (n_items) begin
      if (run_left == 0) begin
        bias     = mix_bias_e'($urandom_range(0, 2));
        run_left = $urandom_range(32, 64);
      end
      run_left--;
      send_random(pick_op(bias));
    end
  endtask

  task automatic test_search_delete_full();
    int r;
    fill_to_full();
    repeat (140) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_item(OP_DELETE, pick_key());
      end else if (r < 85) begin
        send_item(OP_SEARCH, pick_key());
      end else begin
        send_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_sequence();
    test_directed_extremes();
    test_full_boundary();
    test_random_ops(1000);
    test_search_delete_full();
    idle_enable = 1'b0;
    test_random_ops(150);
    wait_drained();

    $display("Covered %0d operations, %0d results checked: %0d full pushes, %0d empty pops,",
             ops_sent, results_checked, full_seen, empty_seen);
    $display("%0d delete/search hits and %0d misses.", hits_seen, misses_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
